// ===== sv/ietr_pkg.sv =====
// Package for the input event ring with active touch set.
// Sizes, command and event codes, word layouts and controller types.
// No dependencies; imported by every module of the block.
package ietr_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TOUCH_CAP   = 10;

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TIDX_W = (TOUCH_CAP > 1) ? $clog2(TOUCH_CAP) : 1;
  localparam int TCNT_W = $clog2(TOUCH_CAP + 1);

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_TOUCH_DOWN   = 3'd0,
    EV_TOUCH_MOVE   = 3'd1,
    EV_TOUCH_UP     = 3'd2,
    EV_TOUCH_CANCEL = 3'd3,
    EV_KEY_DOWN     = 3'd4,
    EV_KEY_UP       = 3'd5
  } evt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // One stored event, event_type in the lowest bits
  typedef struct packed {
    logic signed [31:0] key_val;
    logic [31:0]        pressure;
    logic [31:0]        touch_y;
    logic [31:0]        touch_x;
    logic signed [31:0] ptr_id;
    logic [2:0]         event_type;
  } entry_t;

  localparam int IN_BITS = $bits(entry_t);
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [IN_W-IN_BITS-1:0] pad;
    entry_t                  entry;
  } in_t;

  localparam int RES_BITS = 1 + TCNT_W + 32 + QCNT_W + $bits(entry_t) + 2;
  localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [RES_W-RES_BITS-1:0] pad;
    logic                      pointer_is_active;
    logic [TCNT_W-1:0]         touch_total;
    logic [31:0]               dropped_count;
    logic [QCNT_W-1:0]         queued_count;
    entry_t                    polled;
    logic                      event_valid;
    logic                      accepted;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// ===== sv/ietr_ctrl.sv =====
// Controller for the input event ring: accept, execute, respond.
// Depends on ietr_pkg; drives the datapath through ctrl_cmd_t.
module ietr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output ietr_pkg::ctrl_cmd_t   ctl
);
  import ietr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        // take the next word in the same cycle the result leaves
        if (m_tready) state_next = s_tvalid ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    ctl.exec = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
      end
      ST_RESP: begin
        m_tvalid = 1'b1;
        s_tready = m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    ctl.load = s_tvalid && s_tready;
  end

endmodule

// ===== sv/ietr_dp.sv =====
// Datapath for the input event ring: operand register, ring memory,
// touch set with its search, counters and the result register.
// Depends on ietr_pkg; sequenced by ietr_ctrl.
module ietr_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ietr_pkg::ctrl_cmd_t  ctl,
  input  logic [1:0]           in_cmd,
  input  ietr_pkg::entry_t     in_entry,
  output ietr_pkg::res_t       result
);
  import ietr_pkg::*;

  // operand register
  logic [1:0]          op_cmd;
  entry_t              op;

  // ring
  entry_t              mem [QUEUE_DEPTH];
  entry_t              rd_data;
  logic [QIDX_W-1:0]   head, head_next, head_inc, wr_addr;
  logic [QCNT_W-1:0]   count, count_next;
  logic [QCNT_W:0]     tail_sum;
  logic                wr_en;
  logic [31:0]         drops, drops_next;

  // touch set
  logic [31:0]         tids [TOUCH_CAP];
  logic [31:0]         tids_next [TOUCH_CAP];
  logic [TCNT_W-1:0]   tcount, tcount_next;
  logic [TOUCH_CAP-1:0] hit;
  logic [TIDX_W-1:0]   pos, last;
  logic                found;

  logic                touch_kind, push_ok;
  res_t                res_next;

  function automatic logic finite_bits(input logic [31:0] v);
    return v[30:23] != 8'hFF;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_cmd <= in_cmd;
      op     <= in_entry;
    end
  end

  // validity of a pushed event
  always_comb begin
    touch_kind = op.event_type <= EV_TOUCH_CANCEL;
    push_ok    = 1'b0;
    if (touch_kind) begin
      push_ok = !op.ptr_id[31] && finite_bits(op.touch_x) &&
                finite_bits(op.touch_y) && finite_bits(op.pressure) &&
                (!op.pressure[31] || op.pressure == 32'h8000_0000);
    end else if (op.event_type inside {EV_KEY_DOWN, EV_KEY_UP}) begin
      push_ok = !op.key_val[31];
    end
  end

  // search the active part of the touch set; lowest match wins
  always_comb begin
    pos = '0;
    for (int i = 0; i < TOUCH_CAP; i++) begin
      hit[i] = (tids[i] == op.ptr_id) && (TCNT_W'(i) < tcount);
    end
    for (int i = TOUCH_CAP - 1; i >= 0; i--) begin
      if (hit[i]) pos = TIDX_W'(i);
    end
    found = |hit;
    last  = TIDX_W'(tcount - TCNT_W'(1));
  end

  always_comb begin
    head_inc = (head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + QIDX_W'(1);
    tail_sum = (QCNT_W + 1)'(head) + (QCNT_W + 1)'(count);
    if (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
      wr_addr = QIDX_W'(tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH));
    end else begin
      wr_addr = QIDX_W'(tail_sum);
    end
  end

  always_comb begin
    head_next   = head;
    count_next  = count;
    drops_next  = drops;
    tcount_next = tcount;
    tids_next   = tids;
    wr_en       = 1'b0;
    res_next    = '0;
    case (op_cmd)
      CMD_PUSH: begin
        if (push_ok) begin
          wr_en             = 1'b1;
          res_next.accepted = 1'b1;
          if (count == QCNT_W'(QUEUE_DEPTH)) begin
            // full: overwrite the oldest, tail lands on the old head
            head_next  = head_inc;
            drops_next = drops + 32'd1;
          end else begin
            count_next = count + QCNT_W'(1);
          end
          if (op.event_type == EV_TOUCH_DOWN) begin
            if (!found && tcount < TCNT_W'(TOUCH_CAP)) begin
              tids_next[TIDX_W'(tcount)] = op.ptr_id;
              tcount_next = tcount + TCNT_W'(1);
            end
          end else if (op.event_type == EV_TOUCH_UP ||
                       op.event_type == EV_TOUCH_CANCEL) begin
            if (found) begin
              // move the last entry into the hole
              tids_next[pos]  = tids[last];
              tids_next[last] = '1;
              tcount_next     = tcount - TCNT_W'(1);
            end
          end
        end
      end
      CMD_POLL: begin
        if (count != '0) begin
          res_next.event_valid = 1'b1;
          res_next.polled      = rd_data;
          head_next            = head_inc;
          count_next           = count - QCNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        head_next   = '0;
        count_next  = '0;
        tcount_next = '0;
        for (int i = 0; i < TOUCH_CAP; i++) tids_next[i] = '1;
      end
      CMD_QUERY: begin
        res_next.pointer_is_active = found;
      end
      default: begin
        res_next = '0;
      end
    endcase
    res_next.queued_count  = count_next;
    res_next.dropped_count = drops_next;
    res_next.touch_total   = tcount_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      drops  <= '0;
      tcount <= '0;
      for (int i = 0; i < TOUCH_CAP; i++) tids[i] <= '1;
    end else if (ctl.exec) begin
      head   <= head_next;
      count  <= count_next;
      drops  <= drops_next;
      tcount <= tcount_next;
      tids   <= tids_next;
    end
  end

  // ring memory: write on execute, read the head every cycle
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) mem[wr_addr] <= op;
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) result <= res_next;
  end

endmodule

// ===== sv/input_event_ring_with_touch_set_top.sv =====
// Top level of the input event ring with active touch set.
// Depends on ietr_pkg, ietr_ctrl and ietr_dp.
//
//   channel  | signals                      | word
//   ---------+------------------------------+---------------------------------
//   s        | s_tvalid s_tready s_tuser    | command + event, one result each
//   m        | m_tvalid m_tready m_tdata    | result of one command
//
// From acceptance a word passes through the execute state, which updates
// the ring, counters and touch set, and then into the result register. The
// ring head is read every cycle into a register, so a poll needs no separate
// read step. A new word is taken only when idle or as the last result leaves.
// Reset clears the ring pointers, counts and touch set; ring contents stay.
// While m_tready is low the result holds and no new word is taken.
module input_event_ring_with_touch_set_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // event_type, ptr_id, touch_x, touch_y, pressure, key_val, zero pad
  input  logic [ietr_pkg::IN_W-1:0]    s_tdata,
  // cmd
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // accepted, event_valid, out_type, out_pointer, out_x, out_y,
  // out_pressure, out_key, queued_count, dropped_count,
  // touch_total, pointer_is_active, zero pad
  output logic [ietr_pkg::RES_W-1:0]   m_tdata
);
  import ietr_pkg::*;

  ctrl_cmd_t ctl;
  in_t       in_word;
  res_t      result;

  assign in_word = in_t'(s_tdata);

  ietr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  ietr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_cmd   (s_tuser),
    .in_entry (in_word.entry),
    .result   (result)
  );

  assign m_tdata = result;

  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.queued_count <= QCNT_W'(QUEUE_DEPTH)) &&
                 (result.touch_total <= TCNT_W'(TOUCH_CAP)))
    else $error("count beyond capacity");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result shown in the execute cycle");

  a_one_kind_of_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(result.accepted && result.event_valid) &&
                 !(result.accepted && result.pointer_is_active) &&
                 !(result.event_valid && result.pointer_is_active))
    else $error("result flags from more than one command");

endmodule
